[sv/mpk_pkg.sv]
package mpk_pkg;

	localparam int PRICE_W  = 16;
	localparam int PROFIT_W = 32;
	localparam int CFG_W    = 5;
	localparam int MAX_TX_DEFAULT = 16;
	localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(2);
	localparam logic [PROFIT_W-1:0] PROFIT_TOP = '1;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic               series_start;
	} mpk_in_t;

	typedef struct packed {
		logic [PROFIT_W-1:0] best_profit;
		logic                saturated;
	} mpk_out_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic                      upd;
		logic                      clr;
		logic signed [PRICE_W:0]   diff;
		logic        [PRICE_W-1:0] gain;
	} mpk_ctl_t;

endpackage

[sv/mpk_cell.sv]
module mpk_cell
	import mpk_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  mpk_ctl_t            ctl,
	input  logic [PROFIT_W-1:0] below,
	output logic [PROFIT_W-1:0] best,
	output logic                sat
);

	logic [PROFIT_W-1:0] best_q;
	logic [PROFIT_W-1:0] sold_q;

	logic signed [PROFIT_W+1:0] fresh;
	logic signed [PROFIT_W+1:0] carry;
	logic signed [PROFIT_W+1:0] pick;
	logic        [PROFIT_W-1:0] sold_nxt;
	logic                       over;

	always_comb begin
		fresh = $signed({2'b00, below}) + $signed({(PROFIT_W+2-PRICE_W)'(0), ctl.gain});
		carry = $signed({2'b00, sold_q}) + (PROFIT_W+2)'(ctl.diff);
		pick  = (fresh > carry) ? fresh : carry;
		over  = 1'b0;
		if (pick < 0) begin
			sold_nxt = '0;
		end else if (pick > $signed({2'b00, PROFIT_TOP})) begin
			sold_nxt = PROFIT_TOP;
			over     = 1'b1;
		end else begin
			sold_nxt = pick[PROFIT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
			sold_q <= '0;
		end else if (ctl.clr) begin
			best_q <= '0;
			sold_q <= '0;
		end else if (ctl.upd) begin
			sold_q <= sold_nxt;
			if (sold_nxt > best_q) begin
				best_q <= sold_nxt;
			end
		end
	end

	assign best = best_q;
	assign sat  = ctl.upd & over;

endmodule

[sv/mpk_row.sv]
module mpk_row
	import mpk_pkg::*;
#(
	parameter int MAX_TX = MAX_TX_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mpk_ctl_t                         ctl,
	output logic [MAX_TX-1:0][PROFIT_W-1:0]  best,
	output logic                             sat_any
);

	logic [MAX_TX-1:0] sat_v;

	for (genvar j = 0; j < MAX_TX; j++) begin : g_cell
		logic [PROFIT_W-1:0] below;
		if (j == 0) begin : g_first
			assign below = '0;
		end else begin : g_next
			assign below = best[j-1];
		end
		mpk_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.below  (below),
			.best   (best[j]),
			.sat    (sat_v[j])
		);
	end

	assign sat_any = |sat_v;

endmodule

[sv/max_profit_k_transactions_top.sv]
// Best profit from at most max_transactions buy-sell transactions over a running
// price series. Each transfer on the input carries one day's price; series_start
// clears every stored profit and the saturation flag and reports 0 for that day.
// A row of MAX_TX cells, one per transaction count, updates all counts in the
// cycle an item is taken; the answer for the configured limit is selected from
// the row and registered when the output is free; a new item is not taken
// until the pending result is loaded into the output register. The output register
// holds a result under stall while the next item is taken. Limits above MAX_TX
// are clamped, a limit of zero gives 0. Profits saturate at 2^32-1 and the
// saturated flag stays set until reset or series start. Write max_transactions
// only while the block is idle; writes are always taken.
module max_profit_k_transactions_top
	import mpk_pkg::*;
#(
	parameter int MAX_TX = MAX_TX_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  mpk_in_t          in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output mpk_out_t         out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int IDX_W = (MAX_TX > 1) ? $clog2(MAX_TX) : 1;
	localparam int LIM_W = ($clog2(MAX_TX + 1) > CFG_W) ? $clog2(MAX_TX + 1) : CFG_W;

	logic [CFG_W-1:0]   limit_q;
	logic [PRICE_W-1:0] prev_q;
	logic               sat_q;
	logic               pend_q;
	logic               out_valid_q;
	mpk_out_t           out_q;

	mpk_ctl_t                        ctl;
	logic [MAX_TX-1:0][PROFIT_W-1:0] best_v;
	logic                            sat_any;
	logic                            in_xfer;
	logic                            load;
	logic [LIM_W-1:0]                lim_c;
	logic [IDX_W-1:0]                sel;
	logic [PROFIT_W-1:0]             answer;

	assign in_xfer   = in_valid & ~in_stall;
	assign in_stall  = pend_q;
	assign load      = pend_q & (~out_valid_q | ~out_stall);
	assign cfg_ready = 1'b1;

	always_comb begin
		ctl.upd  = in_xfer & ~in_data.series_start;
		ctl.clr  = in_xfer & in_data.series_start;
		ctl.diff = $signed({1'b0, in_data.price}) - $signed({1'b0, prev_q});
		ctl.gain = (ctl.diff > 0) ? ctl.diff[PRICE_W-1:0] : '0;
	end

	mpk_row #(
		.MAX_TX (MAX_TX)
	) u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.best    (best_v),
		.sat_any (sat_any)
	);

	// limit clamp and answer select
	always_comb begin
		lim_c = LIM_W'(limit_q);
		if (lim_c > LIM_W'(MAX_TX)) begin
			lim_c = LIM_W'(MAX_TX);
		end
		sel    = IDX_W'(lim_c - LIM_W'(1));
		answer = (lim_c == '0) ? '0 : best_v[sel];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			prev_q      <= '0;
			sat_q       <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (in_xfer) begin
				prev_q <= in_data.price;
				pend_q <= 1'b1;
				if (in_data.series_start) begin
					sat_q <= 1'b0;
				end else if (sat_any) begin
					sat_q <= 1'b1;
				end
			end else if (load) begin
				pend_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.best_profit <= answer;
			out_q.saturated   <= sat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("item taken while previous one still pending");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_data.series_start) |=> (best_v == '0))
		else $error("series start did not clear the cell row");

	a_row_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> $stable(best_v))
		else $error("cell row changed while a result was pending");

endmodule
